// ===== sv/fpnd_pkg.sv =====
// shared types, constants and the 16.16 multiply for the newton divider
package fpnd_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned NORM_N  = 5;
	localparam int unsigned NWT_N   = 4;
	localparam int unsigned NORM_B  = 30;

	localparam logic [DATA_W-1:0] FX_TWO  = 32'h0002_0000;
	localparam logic [DATA_W-1:0] FX_SEED = 32'd3;

	typedef enum logic {
		ACT_MUL = 1'b0,
		ACT_DIV = 1'b1
	} act_t;

	typedef struct packed {
		act_t               action;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} op_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               divide_error;
	} res_t;

	typedef struct packed {
		logic              div;
		logic              neg;
		logic              err;
		logic [DATA_W-1:0] td;
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] n;
	} norm_t;

	typedef struct packed {
		logic              div;
		logic              neg;
		logic              err;
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] t1;
		logic [DATA_W-1:0] t2;
	} nwt_t;

	function automatic logic [DATA_W-1:0] fx_mul(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic signed [2*DATA_W-1:0] p;
		p = signed'(a) * signed'(b);
		return p[FRAC_W +: DATA_W];
	endfunction

endpackage

// ===== sv/fixed_point_newton_divider.sv =====
// top level: signed 16.16 multiply and newton-raphson divide over a chain of cells
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------------------
//  op      | op_valid  | op_stall  | op  : action, operand_a, operand_b
//  res     | res_valid | res_stall | res : result, divide_error
//
//  the path runs through five normalize cells, four newton cells and one output register
//  one word enters per cycle while the output register is free or being taken
//  the cell chain moves as a whole; a stalled result holds every cell in place
//  reset clears only the valid bits of the cells and the output register
module fixed_point_newton_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_stall,
	input  fpnd_pkg::op_t  op,
	output logic          res_valid,
	input  logic          res_stall,
	output fpnd_pkg::res_t res
);
	import fpnd_pkg::*;

	logic              adv;
	logic [DATA_W-1:0] b_raw;
	logic [DATA_W-1:0] b_abs;
	norm_t             norm_in;
	nwt_t              nwt_in;

	logic              norm_vld [NORM_N+1];
	norm_t             norm_d   [NORM_N+1];
	logic              nwt_vld  [NWT_N+1];
	nwt_t              nwt_d    [NWT_N+1];

	logic              res_valid_q;
	res_t              res_q;
	logic              res_div_q;
	logic [DATA_W-1:0] quo;

	assign adv      = !res_valid_q || !res_stall;
	assign op_stall = !adv;

	always_comb begin
		b_raw          = op.operand_b;
		b_abs          = b_raw[DATA_W-1] ? (32'd0 - b_raw) : b_raw;
		norm_in.div    = (op.action == ACT_DIV);
		norm_in.neg    = b_raw[DATA_W-1];
		norm_in.err    = (op.action == ACT_DIV) && ((b_abs == '0) || b_abs[DATA_W-1]);
		norm_in.td     = b_abs;
		norm_in.g      = FX_SEED;
		norm_in.d      = (op.action == ACT_DIV) ? b_abs : b_raw;
		norm_in.n      = op.operand_a;
	end

	assign norm_vld[0] = op_valid;
	assign norm_d[0]   = norm_in;

	for (genvar i = 0; i < NORM_N; i++) begin : g_norm
		fpnd_norm_cell #(
			.Shift(16 >> i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_in(norm_vld[i]),
			.din   (norm_d[i]),
			.vld_q (norm_vld[i+1]),
			.dout_q(norm_d[i+1])
		);
	end

	always_comb begin
		nwt_in.div = norm_d[NORM_N].div;
		nwt_in.neg = norm_d[NORM_N].neg;
		nwt_in.err = norm_d[NORM_N].err;
		nwt_in.g   = norm_d[NORM_N].g;
		nwt_in.t1  = norm_d[NORM_N].d;
		nwt_in.t2  = norm_d[NORM_N].n;
	end

	assign nwt_vld[0] = norm_vld[NORM_N];
	assign nwt_d[0]   = nwt_in;

	for (genvar i = 0; i < NWT_N; i++) begin : g_nwt
		fpnd_nwt_cell #(
			.First(i == 0)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_in(nwt_vld[i]),
			.din   (nwt_d[i]),
			.vld_q (nwt_vld[i+1]),
			.dout_q(nwt_d[i+1])
		);
	end

	assign quo = (nwt_d[NWT_N].div && nwt_d[NWT_N].neg) ?
		(32'd0 - nwt_d[NWT_N].t2) : nwt_d[NWT_N].t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= nwt_vld[NWT_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.result       <= nwt_d[NWT_N].err ? '0 : quo;
			res_q.divide_error <= nwt_d[NWT_N].err;
			res_div_q          <= nwt_d[NWT_N].div;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_error |-> res.result == '0)
		else $error("divide error word carries a nonzero result");

	a_mul_no_err : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_div_q |-> !res.divide_error)
		else $error("multiply word flagged a divide error");

	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> res_valid && res_stall)
		else $error("input stalled while the output register was free");

	a_chain_out : assert property (@(posedge clk) disable iff (!arst_n)
		adv && nwt_vld[NWT_N] |=> res_valid)
		else $error("word leaving the last cell was dropped");

	a_chain_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(nwt_vld[NWT_N]) && $stable(norm_vld[NORM_N]))
		else $error("cell chain moved while stalled");

endmodule

// ===== sv/fpnd_norm_cell.sv =====
// one normalize cell: shifts divisor copy and seed left by Shift when the Shift bits from bit 30 down are clear
module fpnd_norm_cell #(
	parameter int unsigned Shift = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_in,
	input  fpnd_pkg::norm_t din,
	output logic           vld_q,
	output fpnd_pkg::norm_t dout_q
);
	import fpnd_pkg::*;

	norm_t nxt;

	always_comb begin
		nxt = din;
		if (din.td[NORM_B -: Shift] == '0) begin
			nxt.td = din.td << Shift;
			nxt.g  = din.g << Shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout_q <= nxt;
		end
	end

endmodule

// ===== sv/fpnd_nwt_cell.sv =====
// newton cell: scales both terms by its factor; after the first, divides only
module fpnd_nwt_cell #(
	parameter bit First = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          vld_in,
	input  fpnd_pkg::nwt_t din,
	output logic          vld_q,
	output fpnd_pkg::nwt_t dout_q
);
	import fpnd_pkg::*;

	logic [DATA_W-1:0] m;
	logic [DATA_W-1:0] p1;
	logic [DATA_W-1:0] p2;
	nwt_t              nxt;

	always_comb begin
		if (First) begin
			m = din.div ? din.g : din.t1;
		end else begin
			m = FX_TWO - din.t1;
		end
		p1  = fx_mul(m, din.t1);
		p2  = fx_mul(m, din.t2);
		nxt = din;
		if (First || din.div) begin
			nxt.t1 = p1;
			nxt.t2 = p2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout_q <= nxt;
		end
	end

endmodule

// ===== tb/fixed_point_newton_divider_tb.sv =====
// testbench for the 16.16 multiply / newton divide unit: directed corners, then random traffic
module fixed_point_newton_divider_tb;
	import fpnd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_WORDS   = 1850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	op_t  op = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	res_t pending_results[$];
	int   mismatch_count = 0;
	bit   op_burst = 1'b0;
	bit   res_burst = 1'b0;

	fixed_point_newton_divider dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] q16_product(input logic [31:0] x, input logic [31:0] y);
		logic signed [63:0] wide;
		wide = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
		return wide[47:16];
	endfunction

	function automatic res_t q16_result(input op_t w);
		res_t r;
		logic [31:0] divisor, shifted, guess, e, q, f;
		logic negative;
		r = '0;
		if (w.action == ACT_MUL) begin
			r.result = q16_product(w.operand_a, w.operand_b);
			return r;
		end
		negative = w.operand_b[31];
		divisor = negative ? 32'd0 - w.operand_b : w.operand_b;
		if (divisor == 32'd0 || divisor[31]) begin
			r.divide_error = 1'b1;
			return r;
		end
		shifted = divisor;
		guess = FX_SEED;
		while (!shifted[30]) begin
			shifted = shifted << 1;
			guess = guess << 1;
		end
		e = q16_product(guess, divisor);
		q = q16_product(guess, w.operand_a);
		repeat (2) begin
			f = FX_TWO - e;
			e = q16_product(f, e);
			q = q16_product(f, q);
		end
		f = FX_TWO - e;
		q = q16_product(f, q);
		r.result = negative ? 32'd0 - q : q;
		return r;
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'd1 << $urandom_range(0, 31);
			1: v = $urandom_range(0, 32'h3_FFFF);
			2: v = 32'h1_0000 + $urandom_range(0, 32'h1FF) - 32'hFF;
			3: begin
				case ($urandom_range(0, 4))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 1))
			v = 32'd0 - v;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic send_word(input act_t act, input logic [31:0] a, input logic [31:0] b);
		op_t w;
		int gap;
		w.action = act;
		w.operand_a = a;
		w.operand_b = b;
		gap = draw_wait(op_burst);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		op <= w;
		@(posedge clk);
		while (op_stall) @(posedge clk);
		pending_results.push_back(q16_result(w));
	endtask

	task automatic test_multiply_extremes();
		send_word(ACT_MUL, 32'h0000_0000, 32'h0000_0000);
		send_word(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
		send_word(ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(ACT_MUL, 32'h0001_0000, 32'hFFFF_0000);
		send_word(ACT_MUL, 32'h0000_8000, 32'h0003_0000);
		send_word(ACT_MUL, 32'hAAAA_5555, 32'h5555_AAAA);
	endtask

	task automatic test_divide_special_divisors();
		send_word(ACT_DIV, 32'h0001_0000, 32'h0000_0000);
		send_word(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(ACT_DIV, 32'h0001_0000, 32'h0000_0001);
		send_word(ACT_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(ACT_DIV, 32'h8000_0000, 32'h8000_0001);
		send_word(ACT_DIV, 32'h0003_0000, 32'h0001_0000);
		send_word(ACT_DIV, 32'h0003_0000, 32'hFFFF_0000);
		send_word(ACT_DIV, 32'h0000_0000, 32'h4000_0000);
		send_word(ACT_DIV, 32'hFFFE_0000, 32'h0000_8000);
		send_word(ACT_DIV, 32'h5555_AAAA, 32'h0007_3333);
		send_word(ACT_DIV, 32'h0001_0000, 32'h0003_0000);
	endtask

	task automatic test_random_traffic(input int count);
		logic [31:0] b;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				op_burst = ($urandom_range(0, 3) == 0);
				res_burst = ($urandom_range(0, 3) == 0);
			end
			b = rand_operand();
			if ($urandom_range(0, 99) < 3)
				b = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
			send_word($urandom_range(0, 1) ? ACT_DIV : ACT_MUL, rand_operand(), b);
		end
		op_burst = 1'b0;
		res_burst = 1'b0;
	endtask

	// result side: random stall before each word, none during result bursts
	initial begin
		int gap;
		while (!arst_n) @(posedge clk);
		forever begin
			gap = draw_wait(res_burst);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word result=%h err=%b",
					res.result, res.divide_error));
			end else begin
				want = pending_results.pop_front();
				if (res.result !== want.result)
					report_mismatch($sformatf("result got %h want %h",
						res.result, want.result));
				if (res.divide_error !== want.divide_error)
					report_mismatch($sformatf("divide_error got %b want %b",
						res.divide_error, want.divide_error));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((op_valid && !op_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_multiply_extremes();
		test_divide_special_divisors();
		test_random_traffic(RANDOM_WORDS);
		op_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
